// ===== sv/ihsa_pkg.sv =====
// Package for the impact heat map splat accumulator.
// Holds operation codes, the decoded command struct and sequencer states.
// No dependencies.
`timescale 1ns / 1ps
package ihsa_pkg;

  localparam int ValueW = 24;
  localparam int PosW = 14;
  localparam logic [ValueW-1:0] ValueMax = {ValueW{1'b1}};

  typedef enum logic [2:0] {
    OP_CLEAR = 3'd0,
    OP_GOAL  = 3'd1,
    OP_WALL  = 3'd2,
    OP_REARM = 3'd3,
    OP_READ  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    CMD_NOP   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_SPLAT = 2'd2,
    CMD_READ  = 2'd3
  } cmd_kind_t;

  // Command handed from the front end to the back end.
  typedef struct packed {
    cmd_kind_t         kind;
    logic signed [15:0] xb;
    logic signed [15:0] zb;
    logic [7:0]        cx;
    logic [7:0]        cz;
    logic              cell_ok;
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_SP_RD, S_SP_WAIT, S_SP_WR,
    S_RD_WAIT, S_RD_DIV, S_RD_COL, S_OUT
  } bst_t;

  // Splat term 32 >> |d|, zero beyond distance five.
  function automatic logic [5:0] splat_term(input logic signed [15:0] d);
    logic [15:0] a;
    a = d[15] ? 16'(-d) : 16'(d);
    if (a > 16'd5) return 6'd0;
    return 6'(32 >> a[2:0]);
  endfunction

endpackage

// ===== sv/ihsa_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module ihsa_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// ===== sv/ihsa_front.sv =====
// Front end: accepts beats, applies the wall latch and computes brackets.
// Depends on ihsa_pkg. Pushes commands into a two-entry queue.
`timescale 1ns / 1ps
module ihsa_front
  import ihsa_pkg::*;
#(
  parameter int COLUMNS = 64,
  parameter int ROWS = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic [12:0]    cfg_wdata,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [2:0]     in_operation,
  input  logic [PosW-1:0] in_pos_x,
  input  logic [PosW-1:0] in_pos_y,
  input  logic [PosW-1:0] in_pos_z,
  input  logic [5:0]     in_cell_x,
  input  logic [4:0]     in_cell_z,
  output logic           q_valid,
  input  logic           q_pop,
  output cmd_t           q_cmd
);
  localparam int ColWidth = 8000 / COLUMNS;
  localparam int RowHeight = 4000 / ROWS;
  localparam int RecipShift = 28;
  localparam logic [24:0] ColRecip =
    25'(((longint'(1) << RecipShift) + longint'(ColWidth) - 1) / longint'(ColWidth));
  localparam logic [24:0] RowRecip =
    25'(((longint'(1) << RecipShift) + longint'(RowHeight) - 1) / longint'(RowHeight));

  logic [12:0] thr_r;
  logic        latch_r;
  cmd_t        q_r [2];
  logic [1:0]  cnt_r;
  logic        take;
  logic        to_head;
  cmd_t        cmd;
  logic signed [15:0] xs, zs, xq, zq;
  logic [15:0] xa, za, xmag, zmag;
  logic [43:0] xprod, zprod;
  logic        wall_hit;

  assign in_ready = (cnt_r != 2'd2);
  assign take = in_valid && in_ready;
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd = q_r[0];
  assign to_head = (cnt_r == 2'd0) || (cnt_r == 2'd1 && q_pop);

  // Truncating division by constants: the magnitude is multiplied by a rounded-up
  // reciprocal and the sign is put back, so the quotient rounds toward zero.
  // Magnitudes stay below 2^14, which keeps the reciprocal error under one step.
  always_comb begin
    xs = 16'(signed'(in_pos_x)) + 16'sd4000;
    zs = 16'(signed'(in_pos_z));
    xa = xs[15] ? 16'(-xs) : 16'(xs);
    za = zs[15] ? 16'(-zs) : 16'(zs);
    xprod = 44'(xa) * 44'(ColRecip);
    zprod = 44'(za) * 44'(RowRecip);
    xmag = xprod[RecipShift +: 16];
    zmag = zprod[RecipShift +: 16];
    xq = xs[15] ? 16'(-signed'(xmag)) : signed'(xmag);
    zq = zs[15] ? 16'(-signed'(zmag)) : signed'(zmag);
    wall_hit = !latch_r && (17'(signed'(in_pos_y)) > signed'({4'd0, thr_r}));
    cmd.xb = xq;
    cmd.zb = zq;
    cmd.cx = 8'(in_cell_x);
    cmd.cz = 8'(in_cell_z);
    cmd.cell_ok = (32'(in_cell_x) < COLUMNS) && (32'(in_cell_z) < ROWS);
    cmd.kind = CMD_NOP;
    unique case (in_operation)
      OP_CLEAR: cmd.kind = CMD_CLEAR;
      OP_GOAL:  cmd.kind = CMD_SPLAT;
      OP_WALL:  cmd.kind = wall_hit ? CMD_SPLAT : CMD_NOP;
      OP_READ:  cmd.kind = CMD_READ;
      default:  cmd.kind = CMD_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= 13'd4900;
      latch_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (cfg_we) thr_r <= cfg_wdata;
      if (take) begin
        unique case (in_operation)
          OP_CLEAR, OP_GOAL, OP_REARM: latch_r <= 1'b0;
          OP_WALL: if (wall_hit) latch_r <= 1'b1;
          default: ;
        endcase
      end
      cnt_r <= cnt_r + 2'(take) - 2'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (take && to_head) q_r[0] <= cmd;
    else if (q_pop) q_r[0] <= q_r[1];
    if (take && !to_head) q_r[1] <= cmd;
  end

`ifndef NO_ASSERTIONS
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("pop from empty queue");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count overflow");
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2) |-> !in_ready) else $error("ready while full");
`endif
endmodule

// ===== sv/ihsa_back.sv =====
// Back end: clears, splats by read-modify-write, and reads with colormap.
// Depends on ihsa_pkg and ihsa_ram.
`timescale 1ns / 1ps
module ihsa_back
  import ihsa_pkg::*;
#(
  parameter int COLUMNS = 64,
  parameter int ROWS = 32,
  parameter int KERNEL_RADIUS = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  output logic              q_pop,
  input  cmd_t              q_cmd,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ValueW-1:0] out_cell_value,
  output logic [ValueW-1:0] out_peak_value,
  output logic              out_cell_visible,
  output logic [7:0]        out_red,
  output logic [7:0]        out_green,
  output logic [7:0]        out_blue,
  output logic [7:0]        out_alpha
);
  localparam int Depth = COLUMNS * ROWS;
  localparam int AW = $clog2(Depth);
  localparam int CW = $clog2(COLUMNS);
  localparam int RW = $clog2(ROWS);

  bst_t st_r, st_nxt;
  logic boot_r;
  cmd_t c_r;
  logic signed [15:0] x_r, z_r;
  logic [CW-1:0] cc_r;
  logic [RW-1:0] cr_r;
  logic [ValueW-1:0] peak_r, val_r;
  logic [ValueW+9:0] rem_r;
  logic [10:0] quo_r;
  logic [4:0]  dcnt_r;
  logic [7:0] r_r, g_r, b_r, a_r;

  logic we;
  logic [AW-1:0] addr;
  logic [ValueW-1:0] wdata, rdata;
  logic [ValueW:0] sum;
  logic in_grid, x_last, z_last, clr_last;
  logic [12:0] p5;
  logic [10:0] pc;

  ihsa_ram #(.WIDTH(ValueW), .DEPTH(Depth)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata));

  always_comb begin
    // A cell counts only inside the grid and inside the kernel window.
    in_grid = (x_r >= 0) && (x_r < 16'(COLUMNS)) && (z_r >= 0) && (z_r < 16'(ROWS)) &&
              (x_r <= c_r.xb + 16'(KERNEL_RADIUS)) && (z_r <= c_r.zb + 16'(KERNEL_RADIUS));
    z_last = (z_r >= c_r.zb + 16'(KERNEL_RADIUS)) || (z_r >= 16'(ROWS - 1));
    x_last = (x_r >= c_r.xb + 16'(KERNEL_RADIUS)) || (x_r >= 16'(COLUMNS - 1));
    clr_last = (cc_r == CW'(COLUMNS - 1)) && (cr_r == RW'(ROWS - 1));
    sum = {1'b0, rdata} + 25'(splat_term(x_r - c_r.xb)) + 25'(splat_term(z_r - c_r.zb));
    wdata = sum[ValueW] ? ValueMax : sum[ValueW-1:0];
    we = 1'b0;
    addr = AW'({cc_r, cr_r});
    unique case (st_r)
      // The read address goes out while the command is popped, so the cell
      // is in rdata in the cycle after.
      S_IDLE: addr = AW'({q_cmd.cx[CW-1:0], q_cmd.cz[RW-1:0]});
      S_CLR: begin
        we = 1'b1;
        wdata = '0;
      end
      S_SP_RD, S_SP_WAIT: addr = AW'({x_r[CW-1:0], z_r[RW-1:0]});
      S_SP_WR: begin
        addr = AW'({x_r[CW-1:0], z_r[RW-1:0]});
        we = in_grid;
      end
      default: ;
    endcase
    if (COLUMNS * ROWS != (1 << AW) || (1 << CW) != COLUMNS) begin
      // Non power-of-two grid: linear address.
      if (st_r == S_SP_RD || st_r == S_SP_WAIT || st_r == S_SP_WR)
        addr = AW'(32'(x_r) * ROWS + 32'(z_r));
      else if (st_r == S_IDLE)
        addr = AW'(32'(q_cmd.cx) * ROWS + 32'(q_cmd.cz));
      else
        addr = AW'(32'(cc_r) * ROWS + 32'(cr_r));
    end
  end

  always_comb begin
    st_nxt = st_r;
    q_pop = 1'b0;
    unique case (st_r)
      S_IDLE: if (q_valid) begin
        q_pop = 1'b1;
        unique case (q_cmd.kind)
          CMD_CLEAR: st_nxt = S_CLR;
          CMD_SPLAT: st_nxt = S_SP_RD;
          CMD_READ:  st_nxt = S_RD_WAIT;
          default:   st_nxt = S_OUT;
        endcase
      end
      // The clearing pass after reset returns to idle without a result.
      S_CLR:     if (clr_last) st_nxt = boot_r ? S_IDLE : S_OUT;
      S_SP_RD:   st_nxt = S_SP_WAIT;
      S_SP_WAIT: st_nxt = S_SP_WR;
      S_SP_WR:   st_nxt = (x_last && z_last) ? S_OUT : S_SP_RD;
      S_RD_WAIT: st_nxt = S_RD_DIV;
      S_RD_DIV:  if (dcnt_r == 5'd0) st_nxt = S_RD_COL;
      S_RD_COL:  st_nxt = S_OUT;
      S_OUT:     if (out_ready) st_nxt = S_IDLE;
      default:   st_nxt = S_IDLE;
    endcase
  end

  // Colormap from the clamped ratio.
  always_comb begin
    pc = (quo_r > 11'd1024) ? 11'd1024 : quo_r;
    p5 = 13'(pc) * 13'd5;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR;
      boot_r <= 1'b1;
      peak_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (st_r == S_CLR && clr_last) boot_r <= 1'b0;
      if (st_r == S_IDLE && q_valid && q_cmd.kind == CMD_CLEAR) peak_r <= '0;
      if (st_r == S_SP_WR && in_grid && wdata > peak_r) peak_r <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cc_r <= '0;
      cr_r <= '0;
    end else begin
      unique case (st_r)
        S_IDLE: begin
          c_r <= q_cmd;
          cc_r <= (q_cmd.kind == CMD_CLEAR) ? '0 : q_cmd.cx[CW-1:0];
          cr_r <= (q_cmd.kind == CMD_CLEAR) ? '0 : q_cmd.cz[RW-1:0];
          x_r <= (q_cmd.xb - 16'(KERNEL_RADIUS) < 0) ? 16'sd0 : q_cmd.xb - 16'(KERNEL_RADIUS);
          z_r <= (q_cmd.zb - 16'(KERNEL_RADIUS) < 0) ? 16'sd0 : q_cmd.zb - 16'(KERNEL_RADIUS);
          val_r <= '0; r_r <= '0; g_r <= '0; b_r <= '0; a_r <= '0;
        end
        S_CLR: begin
          if (cr_r == RW'(ROWS - 1)) begin
            cr_r <= '0;
            cc_r <= cc_r + 1'b1;
          end else cr_r <= cr_r + 1'b1;
        end
        S_SP_WR: begin
          if (z_last) begin
            z_r <= (c_r.zb - 16'(KERNEL_RADIUS) < 0) ? 16'sd0 : c_r.zb - 16'(KERNEL_RADIUS);
            x_r <= x_r + 16'sd1;
          end else z_r <= z_r + 16'sd1;
        end
        S_RD_WAIT: begin
          val_r <= c_r.cell_ok ? rdata : '0;
          rem_r <= '0;
          quo_r <= '0;
          dcnt_r <= 5'd11;
        end
        // Restoring division of value*1024 by peak, one quotient bit a cycle.
        // value <= peak always, so the quotient fits in 11 bits.
        S_RD_DIV: begin
          logic [ValueW+10:0] t;
          t = {rem_r, ((dcnt_r == 5'd11) ? 1'b0 : 1'b0)};
          if (dcnt_r == 5'd11) begin
            rem_r <= 34'(val_r);
            quo_r <= '0;
            dcnt_r <= 5'd10;
          end else begin
            t = {rem_r, 1'b0};
            if (dcnt_r == 5'd10) t = 35'(rem_r);
            if (peak_r != '0 && t >= 35'(peak_r)) begin
              rem_r <= 34'(t - 35'(peak_r));
              quo_r <= {quo_r[9:0], 1'b1};
            end else begin
              rem_r <= 34'(t);
              quo_r <= {quo_r[9:0], 1'b0};
            end
            dcnt_r <= dcnt_r - 5'd1;
          end
        end
        S_RD_COL: begin
          priority if (p5 <= 13'd1024) begin
            r_r <= '0;
            g_r <= '0;
            b_r <= 8'((21'd255 * 21'(p5)) >> 10);
          end else if (p5 <= 13'd2048) begin
            r_r <= '0;
            g_r <= 8'((21'd255 * 21'(p5 - 13'd1024)) >> 10);
            b_r <= 8'd255;
          end else if (p5 <= 13'd3072) begin
            r_r <= '0;
            g_r <= 8'd255;
            b_r <= 8'((21'd255 * 21'(13'd3072 - p5)) >> 10);
          end else if (p5 <= 13'd4096) begin
            r_r <= 8'((21'd255 * 21'(p5 - 13'd3072)) >> 10);
            g_r <= 8'd255;
            b_r <= '0;
          end else begin
            r_r <= 8'd255;
            g_r <= 8'((21'd255 * 21'(13'd5120 - p5)) >> 10);
            b_r <= '0;
          end
          a_r <= 8'(19'd50 + ((19'd200 * 19'(pc)) >> 10));
        end
        default: ;
      endcase
    end
  end

  assign out_valid = (st_r == S_OUT);
  assign out_cell_value = val_r;
  assign out_peak_value = peak_r;
  assign out_cell_visible = (val_r != '0);
  assign out_red = r_r;
  assign out_green = g_r;
  assign out_blue = b_r;
  assign out_alpha = a_r;

`ifndef NO_ASSERTIONS
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> st_r == S_IDLE) else $error("pop outside idle");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && $stable(out_cell_value))
    else $error("result dropped");
  a_peak_mono: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_SP_WR) |=> peak_r >= $past(peak_r)) else $error("peak fell");
  a_no_write_read: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_RD_DIV || st_r == S_OUT) |-> !we) else $error("write during read");
`endif
endmodule

// ===== sv/impact_heatmap_splat_accumulator_top.sv =====
// Top level of the impact heat map splat accumulator.
// A read fetches the cell, divides it by the peak and applies the colormap; a splat reads
// and writes each visited cell (up to 121 cells); a clear zeroes all COLUMNS*ROWS cells.
// One item at a time in the back end, set by the single RAM port; a two-beat queue
// lets the front end take beats while the back end works.
// Reset: synchronous active-low rst_n, then a clearing pass zeroes the grid.
`timescale 1ns / 1ps
module impact_heatmap_splat_accumulator_top
  import ihsa_pkg::*;
#(
  parameter int COLUMNS = 64,
  parameter int ROWS = 32,
  parameter int KERNEL_RADIUS = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [12:0]       cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        in_operation,
  input  logic [PosW-1:0]   in_pos_x,
  input  logic [PosW-1:0]   in_pos_y,
  input  logic [PosW-1:0]   in_pos_z,
  input  logic [5:0]        in_cell_x,
  input  logic [4:0]        in_cell_z,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ValueW-1:0] out_cell_value,
  output logic [ValueW-1:0] out_peak_value,
  output logic              out_cell_visible,
  output logic [7:0]        out_red,
  output logic [7:0]        out_green,
  output logic [7:0]        out_blue,
  output logic [7:0]        out_alpha
);
  // The front end decodes each beat, applies the wall latch and threshold,
  // and computes the X and Z brackets. Commands wait in a short queue.
  logic q_valid, q_pop;
  cmd_t q_cmd;

  ihsa_front #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_front (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_operation(in_operation),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_pos_z(in_pos_z),
    .in_cell_x(in_cell_x), .in_cell_z(in_cell_z),
    .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd));

  // The back end owns the heat store and the peak, and produces one
  // result beat per command.
  ihsa_back #(.COLUMNS(COLUMNS), .ROWS(ROWS), .KERNEL_RADIUS(KERNEL_RADIUS)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_cell_value(out_cell_value), .out_peak_value(out_peak_value),
    .out_cell_visible(out_cell_visible), .out_red(out_red),
    .out_green(out_green), .out_blue(out_blue), .out_alpha(out_alpha));
endmodule
